// ----- hw/rtl/lpfe_pkg.sv -----
// Package for the LED PWM fade engine: request kinds, register indexes,
// microcode word types and the control program held in read-only form.
// Depends on nothing; used by led_pwm_fade_engine.
`default_nettype none

package lpfe_pkg;

	// Default full-scale PWM level.
	localparam int unsigned PWM_MAX_DEF = 4095;

	// Full scale of a percentage.
	localparam logic [6:0] PCT_FULL = 7'd100;

	// Request kinds on the input channel.
	localparam logic [1:0] KIND_SET  = 2'd0;
	localparam logic [1:0] KIND_TICK = 2'd1;
	localparam logic [1:0] KIND_IDLE = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_TICKS_NORMAL  = 2'd0;
	localparam logic [1:0] CFG_TICKS_STANDBY = 2'd1;
	localparam logic [1:0] CFG_STANDBY_PCT   = 2'd2;

	// Datapath operation carried by one control word.
	typedef enum logic [4:0] {
		OP_NOP,
		OP_LATCH,
		OP_DIV_START,
		OP_WB_START,
		OP_DIV_GOAL,
		OP_WB_GOAL,
		OP_DIFF,
		OP_DIV_DELAY,
		OP_WB_DELAY,
		OP_DIV_STRIDE,
		OP_WB_STRIDE,
		OP_DIV_TRIM,
		OP_WB_TRIM,
		OP_PLACE,
		OP_STEP,
		OP_DIV_PCT,
		OP_WB_PCT,
		OP_EMIT,
		OP_ZERO,
		OP_DEC
	} op_t;

	// Sequencing condition of one control word.
	typedef enum logic [3:0] {
		C_NEXT,
		C_JUMP,
		C_DISPATCH,
		C_DIV_WAIT,
		C_EMIT_WAIT,
		C_ZERO_STEPS,
		C_MANY_STEPS,
		C_IDLE_TICK,
		C_DELAY_LE1
	} cond_t;

	typedef logic [4:0] upc_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		upc_t  target;
	} uword_t;

	// Program labels.
	localparam upc_t PC_IDLE   = 5'd0;
	localparam upc_t PC_START  = 5'd1;
	localparam upc_t PC_MANY   = 5'd10;
	localparam upc_t PC_PLACE  = 5'd14;
	localparam upc_t PC_APPLY  = 5'd15;
	localparam upc_t PC_PCT    = 5'd16;
	localparam upc_t PC_EMIT   = 5'd18;
	localparam upc_t PC_ZERO   = 5'd19;
	localparam upc_t PC_TICK   = 5'd20;
	localparam upc_t PC_DEC    = 5'd22;

	// Clamp an 8-bit percentage to 100.
	function automatic logic [6:0] clamp_pct(input logic [7:0] pct);
		logic [6:0] r;
		r = (pct > {1'b0, PCT_FULL}) ? PCT_FULL : pct[6:0];
		return r;
	endfunction

	// Control program. A word holds while its condition says so; the
	// operation then runs in the cycle that leaves the word.
	function automatic uword_t lpfe_ucode(input upc_t pc);
		uword_t w;
		w = '{op: OP_NOP, cond: C_JUMP, target: PC_IDLE};
		case (pc)
			5'd0:  w = '{op: OP_LATCH,      cond: C_DISPATCH,   target: PC_IDLE};
			5'd1:  w = '{op: OP_DIV_START,  cond: C_NEXT,       target: PC_IDLE};
			5'd2:  w = '{op: OP_WB_START,   cond: C_DIV_WAIT,   target: 5'd3};
			5'd3:  w = '{op: OP_DIV_GOAL,   cond: C_NEXT,       target: PC_IDLE};
			5'd4:  w = '{op: OP_WB_GOAL,    cond: C_DIV_WAIT,   target: 5'd5};
			5'd5:  w = '{op: OP_DIFF,       cond: C_NEXT,       target: PC_IDLE};
			5'd6:  w = '{op: OP_NOP,        cond: C_ZERO_STEPS, target: PC_ZERO};
			5'd7:  w = '{op: OP_NOP,        cond: C_MANY_STEPS, target: PC_MANY};
			5'd8:  w = '{op: OP_DIV_DELAY,  cond: C_NEXT,       target: PC_IDLE};
			5'd9:  w = '{op: OP_WB_DELAY,   cond: C_DIV_WAIT,   target: PC_PLACE};
			5'd10: w = '{op: OP_DIV_STRIDE, cond: C_NEXT,       target: PC_IDLE};
			5'd11: w = '{op: OP_WB_STRIDE,  cond: C_DIV_WAIT,   target: 5'd12};
			5'd12: w = '{op: OP_DIV_TRIM,   cond: C_NEXT,       target: PC_IDLE};
			5'd13: w = '{op: OP_WB_TRIM,    cond: C_DIV_WAIT,   target: PC_PLACE};
			5'd14: w = '{op: OP_PLACE,      cond: C_NEXT,       target: PC_IDLE};
			5'd15: w = '{op: OP_STEP,       cond: C_NEXT,       target: PC_IDLE};
			5'd16: w = '{op: OP_DIV_PCT,    cond: C_NEXT,       target: PC_IDLE};
			5'd17: w = '{op: OP_WB_PCT,     cond: C_DIV_WAIT,   target: PC_EMIT};
			5'd18: w = '{op: OP_EMIT,       cond: C_EMIT_WAIT,  target: PC_IDLE};
			5'd19: w = '{op: OP_ZERO,       cond: C_JUMP,       target: PC_PCT};
			5'd20: w = '{op: OP_NOP,        cond: C_IDLE_TICK,  target: PC_EMIT};
			5'd21: w = '{op: OP_NOP,        cond: C_DELAY_LE1,  target: PC_APPLY};
			5'd22: w = '{op: OP_DEC,        cond: C_JUMP,       target: PC_EMIT};
			default: w = '{op: OP_NOP, cond: C_JUMP, target: PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lpfe_div.sv -----
// Restoring divider for the fade engine: one quotient bit per cycle.
// Self-contained; instantiated by led_pwm_fade_engine.
`default_nettype none

module lpfe_div #(
	parameter int unsigned W = 19
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              busy,
	output logic [W-1:0]      quotient,
	output logic [W-1:0]      remainder
);

	localparam int unsigned CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    rem_sh;
	logic [W:0]    trial;

	// One trial subtraction of the shifted partial remainder.
	always_comb begin
		rem_sh = {rem_q, quo_q[W-1]};
		trial  = rem_sh - {1'b0, dvs_q};
	end

	// Iteration counter; a new division restarts it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Dividend shifts out as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy      = (cnt_q != '0);
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ----- hw/rtl/led_pwm_fade_engine.sv -----
// Top level of the LED PWM fade engine: microcoded sequencer and datapath.
// Depends on lpfe_pkg and lpfe_div.
//
//   Channel  Handshake               Payload
//   in       in_valid / in_ready     kind, target_percent
//   out      out_valid / out_ready   pwm_level, level_percent, fading
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One request is worked at a time. Percentage and level conversions use a
// reciprocal multiply whose product is registered and then taken; the
// variable divisions run on the shared divider (DW = 17).
// An idle tick or an unused kind goes straight to the emit step, a counting tick
// first counts down and a stepping tick converts the new level first; a fade start
// with no steps uses no division, with a tick or more per step one, else two.
// Reset leaves the level at zero, no fade running and the default timings.
// A result waits in the output register; a stall there holds the sequencer
// at its emit step. Configuration writes are taken every cycle.
`default_nettype none

module led_pwm_fade_engine #(
	parameter int unsigned PWM_MAX = lpfe_pkg::PWM_MAX_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   kind,
	input  wire logic [7:0]                   target_percent,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [$clog2(PWM_MAX + 1)-1:0]    pwm_level,
	output logic [6:0]                        level_percent,
	output logic                              fading,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [1:0]                   cfg_index,
	input  wire logic [15:0]                  cfg_data
);

	import lpfe_pkg::*;

	localparam int unsigned LW = $clog2(PWM_MAX + 1);
	// Divider operands: steps + ticks - 1 is the widest.
	localparam int unsigned DW = ((LW > 16) ? LW : 16) + 1;

	// Reciprocal constants. Both pct * PWM_MAX and level * 100 stay below
	// 2^(LW + 7), so a shift of that width plus the divisor's bits is exact.
	localparam int unsigned NW     = LW + 7;
	localparam int unsigned SH_LVL = NW + 7;
	localparam int unsigned SH_PCT = NW + $clog2(PWM_MAX);
	localparam int unsigned PW     = 2 * LW + 14;
	localparam logic [63:0] RCP_100 = ((64'd1 << SH_LVL) + 64'd99) / 64'd100;
	localparam logic [63:0] RCP_MAX = ((64'd1 << SH_PCT) + 64'(PWM_MAX) - 64'd1)
	                                  / 64'(PWM_MAX);
	localparam logic [63:0] K_LVL   = RCP_100 * 64'(PWM_MAX);
	localparam logic [63:0] K_PCT   = RCP_MAX * 64'd100;

	// Configuration registers.
	logic [15:0] ticks_normal_q;
	logic [15:0] ticks_standby_q;
	logic [6:0]  standby_pct_q;

	// Fade state.
	logic [LW-1:0] level_q;
	logic [6:0]    pct_q;
	logic [LW-1:0] goal_q;
	logic [LW-1:0] stride_q;
	logic [15:0]   step_delay_q;
	logic [15:0]   delay_left_q;
	logic          down_q;
	logic          active_q;
	logic          standby_q;

	// Scratch registers of a fade start.
	logic [6:0]    tgt_q;
	logic [15:0]   ticks_q;
	logic [LW-1:0] start_q;
	logic [LW-1:0] steps_q;
	logic [PW-1:0] prod_q;

	// Sequencer.
	upc_t   pc_q;
	upc_t   pc_d;
	uword_t uw;
	logic   hold;
	logic   go;

	// Divider connection.
	logic          div_start;
	logic [DW-1:0] div_dvd;
	logic [DW-1:0] div_dvs;
	logic          div_busy;
	logic [DW-1:0] div_quo;
	logic [DW-1:0] div_rem;

	logic [LW-1:0] level_next;
	logic          next_standby;
	logic [15:0]   next_ticks;

	// Output register.
	logic [LW-1:0] out_level_q;
	logic [6:0]    out_pct_q;
	logic          out_fading_q;
	logic          out_valid_q;

	// Configuration port.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_normal_q  <= 16'd1000;
			ticks_standby_q <= 16'd5000;
			standby_pct_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TICKS_NORMAL:  ticks_normal_q  <= cfg_data;
				CFG_TICKS_STANDBY: ticks_standby_q <= cfg_data;
				CFG_STANDBY_PCT:   standby_pct_q   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Control word fetch and sequencing.
	always_comb begin
		uw   = lpfe_ucode(pc_q);
		hold = 1'b0;
		pc_d = pc_q + 1'b1;
		case (uw.cond)
			C_NEXT: pc_d = pc_q + 1'b1;
			C_JUMP: pc_d = uw.target;
			C_DISPATCH: begin
				hold = !in_valid;
				case (kind)
					KIND_SET:  pc_d = PC_START;
					KIND_IDLE: pc_d = PC_START;
					KIND_TICK: pc_d = PC_TICK;
					default:   pc_d = PC_EMIT;
				endcase
			end
			C_DIV_WAIT: begin
				hold = div_busy;
				pc_d = uw.target;
			end
			C_EMIT_WAIT: begin
				hold = out_valid_q && !out_ready;
				pc_d = uw.target;
			end
			C_ZERO_STEPS: pc_d = (steps_q == '0) ? uw.target : pc_q + 1'b1;
			C_MANY_STEPS: pc_d = (DW'(steps_q) > DW'(ticks_q)) ? uw.target : pc_q + 1'b1;
			C_IDLE_TICK:  pc_d = !active_q ? uw.target : pc_q + 1'b1;
			C_DELAY_LE1:  pc_d = (delay_left_q <= 16'd1) ? uw.target : pc_q + 1'b1;
			default:      pc_d = PC_IDLE;
		endcase
		go = !hold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else if (go) begin
			pc_q <= pc_d;
		end
	end

	assign in_ready = (pc_q == PC_IDLE);

	// Divider operand selection; only the divisions by a variable use it.
	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = DW'(1);
		case (uw.op)
			OP_DIV_DELAY: begin
				div_start = go;
				div_dvd   = DW'(ticks_q);
				div_dvs   = DW'(steps_q);
			end
			OP_DIV_STRIDE: begin
				div_start = go;
				div_dvd   = DW'(steps_q) + DW'(ticks_q) - DW'(1);
				div_dvs   = DW'(ticks_q);
			end
			OP_DIV_TRIM: begin
				div_start = go;
				div_dvd   = DW'(steps_q);
				div_dvs   = DW'(stride_q);
			end
			default: ;
		endcase
	end

	lpfe_div #(
		.W(DW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Level after one step, and the mode and duration of a fade start.
	always_comb begin
		level_next   = down_q ? (level_q - stride_q) : (level_q + stride_q);
		next_standby = (kind == KIND_IDLE);
		next_ticks   = standby_q ? ticks_standby_q : ticks_normal_q;
		if (next_ticks == '0) begin
			next_ticks = 16'd1;
		end
	end

	// Fade state updated by the datapath operations.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= '0;
			pct_q        <= '0;
			goal_q       <= '0;
			stride_q     <= LW'(1);
			step_delay_q <= 16'd1;
			delay_left_q <= '0;
			down_q       <= 1'b0;
			active_q     <= 1'b0;
			standby_q    <= 1'b0;
		end else if (go) begin
			case (uw.op)
				OP_LATCH: begin
					if (kind == KIND_SET || kind == KIND_IDLE) begin
						standby_q <= next_standby;
					end
				end
				OP_WB_GOAL:   goal_q <= prod_q[SH_LVL +: LW];
				OP_DIFF:      down_q <= (start_q > goal_q);
				OP_WB_DELAY: begin
					stride_q     <= LW'(1);
					step_delay_q <= div_quo[15:0];
				end
				OP_WB_STRIDE: stride_q <= div_quo[LW-1:0];
				OP_WB_TRIM:   step_delay_q <= 16'd1;
				OP_PLACE: begin
					level_q  <= down_q ? (goal_q + steps_q) : (goal_q - steps_q);
					active_q <= 1'b1;
				end
				OP_STEP: begin
					level_q <= level_next;
					if (level_next == goal_q) begin
						active_q     <= 1'b0;
						delay_left_q <= '0;
					end else begin
						delay_left_q <= step_delay_q;
					end
				end
				OP_WB_PCT: pct_q <= prod_q[SH_PCT +: 7];
				OP_ZERO: begin
					level_q      <= goal_q;
					stride_q     <= LW'(1);
					active_q     <= 1'b0;
					delay_left_q <= '0;
				end
				OP_DEC: delay_left_q <= delay_left_q - 16'd1;
				default: ;
			endcase
		end
	end

	// Scratch values of a fade start and the reciprocal products.
	always_ff @(posedge clk) begin
		if (go) begin
			case (uw.op)
				OP_LATCH: begin
					tgt_q   <= (kind == KIND_IDLE) ? clamp_pct({1'b0, standby_pct_q})
					                                : clamp_pct(target_percent);
				end
				OP_DIV_START: begin
					ticks_q <= next_ticks;
					prod_q  <= PW'(64'(pct_q) * K_LVL);
				end
				OP_DIV_GOAL: prod_q <= PW'(64'(tgt_q) * K_LVL);
				OP_DIV_PCT:  prod_q <= PW'(64'(level_q) * K_PCT);
				OP_WB_START: start_q <= prod_q[SH_LVL +: LW];
				OP_DIFF: begin
					steps_q <= (start_q > goal_q) ? (start_q - goal_q) : (goal_q - start_q);
				end
				OP_WB_TRIM: steps_q <= steps_q - div_rem[LW-1:0];
				default: ;
			endcase
		end
	end

	// Result register; a new result may replace one being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && uw.op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && uw.op == OP_EMIT) begin
			out_level_q  <= level_q;
			out_pct_q    <= pct_q;
			out_fading_q <= active_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign pwm_level     = out_level_q;
	assign level_percent = out_pct_q;
	assign fading        = out_fading_q;

endmodule

`default_nettype wire

// ----- sim/led_pwm_fade_engine_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for led_pwm_fade_engine: a clocked driver and monitor around the
// block, with a behavioural fade model predicting every result. Depends on lpfe_pkg and the RTL.

module led_pwm_fade_engine_tb;
	import lpfe_pkg::*;

	localparam int unsigned PWM_FULL    = PWM_MAX_DEF;
	localparam logic [1:0]  KIND_UNUSED = 2'd3;
	localparam logic [1:0]  CFG_UNUSED  = 2'd3;
	localparam int          CYCLE_LIMIT = 1500000;
	localparam int          PHASES      = 10;
	localparam int          PHASE_ITEMS = 113;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] tp;
	} fade_req_t;

	typedef struct packed {
		logic [11:0] level;
		logic [6:0]  pct;
		logic        fading;
	} fade_res_t;

	// Clock and block ports.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  kind = KIND_SET;
	logic [7:0]  target_percent = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [11:0] pwm_level;
	logic [6:0]  level_percent;
	logic        fading;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_TICKS_NORMAL;
	logic [15:0] cfg_data = 16'd0;

	// Model of the fade state and its settings.
	logic [11:0] mdl_level;
	logic [6:0]  mdl_pct;
	logic [11:0] mdl_goal;
	logic [11:0] mdl_stride;
	logic [15:0] mdl_delay;
	logic [15:0] mdl_delay_left;
	logic        mdl_down;
	logic        mdl_busy;
	logic        mdl_standby;
	logic [15:0] norm_ticks;
	logic [15:0] stby_ticks;
	logic [6:0]  stby_pct;

	// Request queue, expected results and bookkeeping.
	fade_req_t fade_requests[$];
	fade_res_t pending_levels[$];
	fade_req_t drv_req;
	fade_res_t want, got;
	logic      in_taken = 1'b0;
	int        burst_left = 1;
	int        gap_left = 0;
	int        stall_left = 0;
	int        rx_mode = 0;
	int        cyc = 0;
	int        errors = 0;
	int        checked = 0;
	int        fades_done = 0;
	int        settings = 0;
	int        kind_count[4] = '{0, 0, 0, 0};

	always #4 clk = ~clk;

	led_pwm_fade_engine u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.target_percent(target_percent),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pwm_level     (pwm_level),
		.level_percent (level_percent),
		.fading        (fading),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Percentage to level, clamped to full scale and truncated.
	function automatic logic [11:0] pct_to_lvl(input logic [7:0] p);
		int unsigned q;
		q = (p > 8'd100) ? 100 : int'(p);
		return 12'((q * PWM_FULL) / 100);
	endfunction

	// Level back to a truncated percentage.
	function automatic logic [6:0] lvl_to_pct(input logic [11:0] l);
		int unsigned q;
		q = int'(l);
		return 7'((q * 100) / PWM_FULL);
	endfunction

	// One step of the fade towards the goal, ending it when the goal is met.
	task automatic take_step();
		mdl_level = mdl_down ? mdl_level - mdl_stride : mdl_level + mdl_stride;
		mdl_pct = lvl_to_pct(mdl_level);
		if (mdl_level == mdl_goal) begin
			mdl_busy = 1'b0;
			mdl_delay_left = 16'd0;
			fades_done++;
		end else begin
			mdl_delay_left = mdl_delay;
		end
	endtask

	// Start or restart a fade from the level that the current percentage maps to.
	task automatic begin_fade(input logic [7:0] tgt);
		int unsigned from, steps, ticks;
		from = int'(pct_to_lvl({1'b0, mdl_pct}));
		ticks = mdl_standby ? int'(stby_ticks) : int'(norm_ticks);
		if (ticks == 0)
			ticks = 1;
		mdl_goal = pct_to_lvl(tgt);
		mdl_down = from > int'(mdl_goal);
		steps = mdl_down ? from - int'(mdl_goal) : int'(mdl_goal) - from;
		if (steps == 0) begin
			// Nothing to fade: hold the goal.
			mdl_level = mdl_goal;
			mdl_pct = lvl_to_pct(mdl_level);
			mdl_stride = 12'd1;
			mdl_busy = 1'b0;
			mdl_delay_left = 16'd0;
		end else begin
			if (steps > ticks) begin
				mdl_stride = 12'((steps + ticks - 1) / ticks);
				steps = steps - (steps % int'(mdl_stride));
				mdl_delay = 16'd1;
			end else begin
				mdl_stride = 12'd1;
				mdl_delay = 16'(ticks / steps);
			end
			mdl_level = mdl_down ? 12'(int'(mdl_goal) + steps) : 12'(int'(mdl_goal) - steps);
			mdl_busy = 1'b1;
			take_step();
		end
	endtask

	// Advance the model by one request and return the result it should give.
	task automatic advance_fade(input logic [1:0] k, input logic [7:0] tp, output fade_res_t r);
		case (k)
			KIND_SET: begin
				mdl_standby = 1'b0;
				begin_fade(tp);
			end
			KIND_IDLE: begin
				mdl_standby = 1'b1;
				begin_fade({1'b0, stby_pct});
			end
			KIND_TICK: begin
				if (mdl_busy) begin
					if (mdl_delay_left <= 16'd1)
						take_step();
					else
						mdl_delay_left = mdl_delay_left - 16'd1;
				end
			end
			default: ;
		endcase
		r = '{level: mdl_level, pct: mdl_pct, fading: mdl_busy};
	endtask

	// Register write over the configuration channel; the model follows on acceptance.
	task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TICKS_NORMAL:  norm_ticks = data;
			CFG_TICKS_STANDBY: stby_ticks = data;
			CFG_STANDBY_PCT:   stby_pct = data[6:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_settings(input logic [15:0] n, input logic [15:0] s,
			input logic [15:0] sp);
		cfg_write(CFG_TICKS_NORMAL, n);
		cfg_write(CFG_TICKS_STANDBY, s);
		cfg_write(CFG_STANDBY_PCT, sp);
		settings++;
	endtask

	task automatic push_req(input logic [1:0] k, input logic [7:0] tp);
		fade_requests.push_back('{kind: k, tp: tp});
	endtask

	// Target percentages weighted towards the ends and the clamped range.
	function automatic logic [7:0] rand_pct();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd100;
			2: return 8'($urandom_range(101, 255));
			default: return 8'($urandom_range(0, 100));
		endcase
	endfunction

	// Mostly short fades so that they run to completion within a burst of ticks.
	function automatic logic [15:0] rand_ticks();
		case ($urandom_range(0, 9))
			0: return 16'($urandom_range(1, 3));
			1: return 16'($urandom_range(100, 5000));
			default: return 16'($urandom_range(2, 40));
		endcase
	endfunction

	// A start request followed by a run of ticks, with some noise mixed in.
	task automatic push_sequences(input int count);
		int pushed, run, r;
		pushed = 0;
		while (pushed < count) begin
			r = $urandom_range(0, 99);
			if (r < 65)
				push_req(KIND_SET, rand_pct());
			else if (r < 90)
				push_req(KIND_IDLE, 8'($urandom));
			else if (r < 95)
				push_req(KIND_UNUSED, 8'($urandom));
			else
				push_req(KIND_TICK, 8'($urandom));
			pushed++;
			run = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 60);
			// The run stops at the requested count.
			if (run > count - pushed)
				run = count - pushed;
			repeat (run) begin
				push_req(KIND_TICK, 8'($urandom));
				pushed++;
			end
		end
	endtask

	// Hold off until every request has gone in and every result has come back.
	task automatic wait_drained();
		while (fade_requests.size() != 0 || in_valid || pending_levels.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Request driver: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (fade_requests.size() != 0) begin
				drv_req = fade_requests.pop_front();
				in_valid <= 1'b1;
				kind <= drv_req.kind;
				target_percent <= drv_req.tp;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 60);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: stall pattern switches between none, short and long stalls.
	always @(negedge clk) begin
		if (arst_n) begin
			if (cyc % 300 == 0)
				rx_mode <= $urandom_range(0, 2);
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				out_ready <= 1'b1;
				if (rx_mode == 1 && $urandom_range(0, 2) == 0)
					stall_left <= $urandom_range(1, 4);
				else if (rx_mode == 2 && $urandom_range(0, 9) == 0)
					stall_left <= $urandom_range(10, 40);
			end
		end
	end

	// Monitor: predict on each accepted request, check each accepted result.
	always @(posedge clk) begin
		cyc++;
		in_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				advance_fade(kind, target_percent, want);
				pending_levels.push_back(want);
				kind_count[kind]++;
			end
			if (out_valid && out_ready) begin
				checked++;
				got = '{level: pwm_level, pct: level_percent, fading: fading};
				if (pending_levels.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display({"Result %0d with no request outstanding: ",
							"level %0d pct %0d fading %0b"},
							checked, got.level, got.pct, got.fading);
				end else begin
					want = pending_levels.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display({"Result %0d mismatch: expected level %0d pct %0d ",
								"fading %0b, got level %0d pct %0d fading %0b"},
								checked, want.level, want.pct, want.fading,
								got.level, got.pct, got.fading);
					end
				end
			end
		end
		if (cyc > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding", cyc,
				pending_levels.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Stimulus sequence and end of run.
	initial begin
		int p;
		mdl_level = 12'd0;
		mdl_pct = 7'd0;
		mdl_goal = 12'd0;
		mdl_stride = 12'd1;
		mdl_delay = 16'd1;
		mdl_delay_left = 16'd0;
		mdl_down = 1'b0;
		mdl_busy = 1'b0;
		mdl_standby = 1'b0;
		norm_ticks = 16'd1000;
		stby_ticks = 16'd5000;
		stby_pct = 7'd0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests on the reset settings: idle tick, unused kind, zero-step fade,
		// full-scale fades, restarts mid-fade, clamping, and standby fades.
		push_req(KIND_TICK, 8'd0);
		push_req(KIND_UNUSED, 8'd255);
		push_req(KIND_SET, 8'd0);
		push_req(KIND_SET, 8'd100);
		push_req(KIND_TICK, 8'd255);
		push_req(KIND_TICK, 8'd0);
		push_req(KIND_TICK, 8'd0);
		push_req(KIND_SET, 8'd255);
		push_req(KIND_TICK, 8'd0);
		push_req(KIND_IDLE, 8'd0);
		push_req(KIND_TICK, 8'd0);
		push_req(KIND_TICK, 8'd0);
		push_req(KIND_SET, 8'd101);
		push_req(KIND_SET, 8'd1);
		push_req(KIND_TICK, 8'd0);
		push_req(KIND_SET, 8'd128);
		push_req(KIND_SET, 8'd50);
		push_req(KIND_UNUSED, 8'd0);
		push_req(KIND_IDLE, 8'd255);
		push_req(KIND_IDLE, 8'd0);
		push_req(KIND_TICK, 8'd0);
		wait_drained();

		// Random phases; the first three use the extreme settings. Each phase pauses
		// half-way until every outstanding result has come back.
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: write_settings(16'd1, 16'd1, 16'd100);
				1: write_settings(16'hFFFF, 16'hFFFF, 16'hFF80);
				2: begin
					write_settings(16'd0, 16'd0, 16'hFFFF);
					cfg_write(CFG_UNUSED, 16'h5A5A);
				end
				default: write_settings(rand_ticks(), rand_ticks(),
					16'($urandom_range(0, 127)));
			endcase
			push_sequences(PHASE_ITEMS / 2);
			wait_drained();
			push_sequences(PHASE_ITEMS - PHASE_ITEMS / 2);
			wait_drained();
		end

		repeat (40) @(posedge clk);
		$display("Covered %0d set, %0d tick, %0d idle and %0d unused requests",
			kind_count[KIND_SET], kind_count[KIND_TICK], kind_count[KIND_IDLE],
			kind_count[KIND_UNUSED]);
		$display("over %0d settings; %0d results checked, %0d fades ran to their goal.",
			settings, checked, fades_done);
		if (errors == 0 && pending_levels.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches.", errors);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
